/* sv/sbtd_pkg.sv */
// sbtd_pkg: shared types, opcode constants and helper functions for the
// shader bytecode token decoder. No dependencies.
package sbtd_pkg;

  localparam int unsigned MaxSources = 8;
  localparam int unsigned DefWords   = 4;

  // configuration port
  localparam int unsigned CfgAddrW      = 3;
  localparam logic        CfgRegVersion = 1'b0;
  localparam logic [1:0]  VersionReset  = 2'd3;

  localparam logic [15:0] OpLoop    = 16'd27;
  localparam logic [15:0] OpDcl     = 16'd31;
  localparam logic [15:0] OpRep     = 16'd38;
  localparam logic [15:0] OpIf      = 16'd40;
  localparam logic [15:0] OpIfc     = 16'd41;
  localparam logic [15:0] OpBreakc  = 16'd45;
  localparam logic [15:0] OpDefb    = 16'd47;
  localparam logic [15:0] OpDefi    = 16'd48;
  localparam logic [15:0] OpDef     = 16'd81;
  localparam logic [15:0] OpBreakp  = 16'd96;
  localparam logic [15:0] OpPhase   = 16'hfffd;
  localparam logic [15:0] OpComment = 16'hfffe;
  localparam logic [15:0] OpEnd     = 16'hffff;

  typedef enum logic [3:0] {
    KindInstr    = 4'd0,
    KindDcl      = 4'd1,
    KindDst      = 4'd2,
    KindSrc      = 4'd3,
    KindPred     = 4'd4,
    KindRelative = 4'd5,
    KindDefWord  = 4'd6,
    KindComment  = 4'd7,
    KindEnd      = 4'd8,
    KindError    = 4'd9
  } kind_e;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] opcode;
    logic [14:0] count;
    logic [4:0]  reg_type;
    logic [10:0] reg_num;
    logic [7:0]  select_bits;
    logic [3:0]  modifier;
    logic [3:0]  dst_shift;
    logic [3:0]  flag_bits;
    logic [31:0] raw_value;
    logic        instr_end;
  } res_t;

  function automatic logic is_flow(input logic [15:0] op);
    return op == OpIf || op == OpIfc || op == OpRep || op == OpLoop ||
           op == OpBreakc || op == OpBreakp;
  endfunction

  function automatic logic is_def(input logic [15:0] op);
    return op == OpDef || op == OpDefi || op == OpDefb;
  endfunction

  function automatic logic [4:0] reg_type_of(input logic [31:0] t);
    return {t[12:11], t[30:28]};
  endfunction

  // relative, centroid, partial; saturate is added for destinations only
  function automatic logic [3:0] reg_flags(input logic [31:0] t);
    return {t[21], t[22], 1'b0, t[13]};
  endfunction

endpackage

/* sv/sbtd_if.sv */
// sbtd_tok_if / sbtd_res_if: valid-ready channels for token and result beats.
// Depends on nothing.
interface sbtd_tok_if;
  logic        valid;
  logic        ready;
  logic [31:0] token_word;

  modport source (output valid, output token_word, input ready);
  modport sink (input valid, input token_word, output ready);
endinterface

interface sbtd_res_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  token_kind;
  logic        [15:0] opcode;
  logic        [14:0] count;
  logic        [4:0]  reg_type;
  logic        [10:0] reg_num;
  logic        [7:0]  select_bits;
  logic        [3:0]  modifier;
  logic signed [3:0]  dst_shift;
  logic        [3:0]  flag_bits;
  logic        [31:0] raw_value;
  logic               instr_end;

  modport source (output valid, output token_kind, output opcode, output count,
                  output reg_type, output reg_num, output select_bits, output modifier,
                  output dst_shift, output flag_bits, output raw_value,
                  output instr_end, input ready);
  modport sink (input valid, input token_kind, input opcode, input count,
                input reg_type, input reg_num, input select_bits, input modifier,
                input dst_shift, input flag_bits, input raw_value,
                input instr_end, output ready);
endinterface

/* sv/shader_bytecode_token_decoder_core.sv */
// shader bytecode token decoder top level: input register, decode, result register.
// Each token beat passes the input register and the decode, and its result beat is
// offered from the result register once that register is free to take it.
// Throughput: one token per cycle while the result channel is ready; the parse state
// updates in the same cycle the token is decoded, so consecutive tokens flow without gaps.
// Reset (rst_ni, async low): parse state to expect a header, version to 3.
// Depends on sbtd_pkg, sbtd_if and the sbtd_* submodules.
module shader_bytecode_token_decoder_core
  import sbtd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sbtd_tok_if.sink            tok_in,
  sbtd_res_if.source          res_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [1:0]  version;
  logic        in_valid;
  logic [31:0] in_token;
  logic        out_free;
  logic        adv;
  res_t        res;

  // a held token moves on when the result register can take it
  assign adv = in_valid && out_free;

  sbtd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .version_o (version)
  );

  sbtd_in_stage u_in (
    .clk_i,
    .rst_ni,
    .tok     (tok_in),
    .take_i  (adv),
    .valid_o (in_valid),
    .token_o (in_token)
  );

  sbtd_decoder u_dec (
    .clk_i,
    .rst_ni,
    .adv_i     (adv),
    .token_i   (in_token),
    .version_i (version),
    .res_o     (res)
  );

  sbtd_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i (adv),
    .res_i  (res),
    .free_o (out_free),
    .res    (res_out)
  );

endmodule

/* sv/sbtd_cfg_regs.sv */
// sbtd_cfg_regs: apb register slice holding the shader major version.
// Depends on sbtd_pkg.
module sbtd_cfg_regs
  import sbtd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [1:0]          version_o
);

  logic [1:0] version_q, version_d;
  logic       hit;

  assign hit    = paddr[CfgAddrW-1] == CfgRegVersion;
  assign pready = 1'b1;

  always_comb begin
    version_d = version_q;
    if (psel && penable && pwrite && hit) begin
      version_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VersionReset;
    end else begin
      version_q <= version_d;
    end
  end

  assign prdata    = hit ? {30'd0, version_q} : 32'd0;
  assign version_o = version_q;

endmodule

/* sv/sbtd_in_stage.sv */
// sbtd_in_stage: input register for token beats.
// Depends on sbtd_pkg and sbtd_tok_if.
module sbtd_in_stage
  import sbtd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sbtd_tok_if.sink    tok,
  input  logic        take_i,
  output logic        valid_o,
  output logic [31:0] token_o
);

  logic        valid_q, valid_d;
  logic [31:0] token_q;
  logic        load;

  // refill in the same cycle the held token moves on
  assign tok.ready = !valid_q || take_i;
  assign load      = tok.valid && tok.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      token_q <= tok.token_word;
    end
  end

  assign valid_o = valid_q;
  assign token_o = token_q;

endmodule

/* sv/sbtd_decoder.sv */
// sbtd_decoder: parse state and the single-pass token decode.
// Depends on sbtd_pkg.
module sbtd_decoder
  import sbtd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [31:0] token_i,
  input  logic [1:0]  version_i,
  output res_t        res_o
);

  localparam logic [2:0] PhHdr    = 3'd0;
  localparam logic [2:0] PhDcl    = 3'd1;
  localparam logic [2:0] PhDst    = 3'd2;
  localparam logic [2:0] PhRelDst = 3'd3;
  localparam logic [2:0] PhOpnd   = 3'd4;
  localparam logic [2:0] PhRelSrc = 3'd5;
  localparam logic [2:0] PhDefw   = 3'd6;
  localparam logic [2:0] PhCmt    = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [14:0] slots_q, slots_d;
  logic [3:0]  slot_q, slot_d;
  logic [15:0] op_q, op_d;
  logic        pred_q, pred_d;
  logic [3:0]  src_q, src_d;
  logic [2:0]  defl_q, defl_d;

  logic [14:0] slots_dec;
  logic [3:0]  slot_inc;
  logic [3:0]  src_inc;
  logic [14:0] len;
  logic [14:0] len_m1;
  logic [15:0] hdr_op;
  logic        special;
  logic        rel;
  logic [2:0]  after_dst;
  logic        after_dst_clr;

  assign slots_dec = (slots_q != 15'd0) ? slots_q - 15'd1 : slots_q;
  assign slot_inc  = (slot_q != 4'hf) ? slot_q + 4'd1 : slot_q;
  assign src_inc   = (src_q != 4'hf) ? src_q + 4'd1 : src_q;
  assign hdr_op    = token_i[15:0];
  assign rel       = token_i[13];
  assign special   = (op_q == OpDcl) || is_def(op_q);
  assign len_m1    = (len > 15'd1) ? len - 15'd1 : 15'd0;

  always_comb begin
    if (hdr_op == OpComment) begin
      len = token_i[30:16];
    end else if (hdr_op == OpEnd || hdr_op == OpPhase) begin
      len = 15'd0;
    end else begin
      len = {11'd0, token_i[27:24]};
    end
  end

  // where a dcl or def goes once its destination is done
  always_comb begin
    after_dst     = PhHdr;
    after_dst_clr = 1'b0;
    if (is_def(op_q) && defl_q != 3'd0) begin
      after_dst     = PhDefw;
      after_dst_clr = 1'b1;
    end
  end

  always_comb begin
    res_o           = '0;
    res_o.raw_value = token_i;
    phase_d = PhHdr;
    slots_d = slots_q;
    slot_d  = slot_q;
    op_d    = op_q;
    pred_d  = pred_q;
    src_d   = src_q;
    defl_d  = defl_q;

    case (phase_q)
      PhHdr: begin
        op_d              = hdr_op;
        pred_d            = token_i[28];
        src_d             = 4'd0;
        slot_d            = 4'd0;
        defl_d            = 3'd0;
        slots_d           = len;
        res_o.count       = len;
        res_o.select_bits = token_i[23:16];
        res_o.flag_bits   = {2'b00, token_i[30], token_i[28]};
        res_o.token_kind  = KindInstr;
        if (hdr_op == OpEnd) begin
          res_o.token_kind = KindEnd;
          phase_d          = PhHdr;
        end else if (hdr_op == OpComment) begin
          phase_d = (len != 15'd0) ? PhCmt : PhHdr;
        end else if (hdr_op == OpDcl) begin
          phase_d = PhDcl;
        end else if (is_def(hdr_op)) begin
          defl_d  = (len_m1 < 15'(DefWords)) ? len_m1[2:0] : 3'(DefWords);
          phase_d = PhDst;
        end else if (is_flow(hdr_op)) begin
          phase_d = (len != 15'd0) ? PhOpnd : PhHdr;
        end else begin
          phase_d = (len != 15'd0) ? PhDst : PhHdr;
        end
      end
      PhDcl: begin
        res_o.token_kind = KindDcl;
        res_o.reg_type   = {1'b0, token_i[30:27]};
        res_o.reg_num    = {7'd0, token_i[19:16]};
        res_o.modifier   = token_i[3:0];
        phase_d          = PhDst;
      end
      PhDst: begin
        res_o.token_kind  = KindDst;
        res_o.reg_type    = reg_type_of(token_i);
        res_o.reg_num     = token_i[10:0];
        res_o.select_bits = {4'd0, token_i[19:16]};
        res_o.dst_shift   = token_i[27:24];
        res_o.flag_bits   = reg_flags(token_i) | {2'b00, token_i[20], 1'b0};
        if (special) begin
          if (rel && version_i == 2'd3) begin
            phase_d = PhRelDst;
          end else begin
            phase_d = after_dst;
            if (after_dst_clr) slot_d = 4'd0;
          end
        end else begin
          slot_d  = slot_inc;
          slots_d = slots_dec;
          if (rel && version_i == 2'd3) begin
            phase_d = PhRelDst;
          end else begin
            phase_d = (slots_dec != 15'd0) ? PhOpnd : PhHdr;
          end
        end
      end
      PhRelDst, PhRelSrc: begin
        res_o.token_kind  = KindRelative;
        res_o.reg_type    = reg_type_of(token_i);
        res_o.reg_num     = token_i[10:0];
        res_o.select_bits = token_i[23:16];
        if (phase_q == PhRelDst && special) begin
          phase_d = after_dst;
          if (after_dst_clr) slot_d = 4'd0;
        end else begin
          slot_d  = slot_inc;
          slots_d = slots_dec;
          phase_d = (slots_dec != 15'd0) ? PhOpnd : PhHdr;
        end
      end
      PhOpnd: begin
        slot_d  = slot_inc;
        slots_d = slots_dec;
        phase_d = (slots_dec != 15'd0) ? PhOpnd : PhHdr;
        if (!is_flow(op_q) && slot_q == 4'd1 && pred_q) begin
          res_o.token_kind  = KindPred;
          res_o.reg_type    = reg_type_of(token_i);
          res_o.reg_num     = token_i[10:0];
          res_o.select_bits = token_i[23:16];
          res_o.modifier    = token_i[27:24];
          res_o.flag_bits   = reg_flags(token_i);
        end else if (src_q >= 4'(MaxSources)) begin
          // overrun: report and consume, no relative token follows
          res_o.token_kind = KindError;
          res_o.count      = {11'd0, src_q};
          src_d            = src_inc;
        end else begin
          res_o.token_kind  = KindSrc;
          res_o.count       = {11'd0, src_q};
          res_o.reg_type    = reg_type_of(token_i);
          res_o.reg_num     = token_i[10:0];
          res_o.select_bits = token_i[23:16];
          res_o.modifier    = token_i[27:24];
          res_o.flag_bits   = reg_flags(token_i);
          src_d             = src_inc;
          if (rel && version_i >= 2'd2) begin
            phase_d = PhRelSrc;
          end
        end
      end
      PhDefw: begin
        res_o.token_kind = KindDefWord;
        res_o.count      = {11'd0, slot_q};
        slot_d           = slot_inc;
        defl_d           = (defl_q != 3'd0) ? defl_q - 3'd1 : defl_q;
        phase_d          = (defl_d != 3'd0) ? PhDefw : PhHdr;
      end
      default: begin
        res_o.token_kind = KindComment;
        slots_d          = slots_dec;
        phase_d          = (slots_dec != 15'd0) ? PhCmt : PhHdr;
      end
    endcase

    res_o.opcode    = op_d;
    res_o.instr_end = phase_d == PhHdr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr;
      slots_q <= 15'd0;
      slot_q  <= 4'd0;
      op_q    <= 16'd0;
      pred_q  <= 1'b0;
      src_q   <= 4'd0;
      defl_q  <= 3'd0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      slots_q <= slots_d;
      slot_q  <= slot_d;
      op_q    <= op_d;
      pred_q  <= pred_d;
      src_q   <= src_d;
      defl_q  <= defl_d;
    end
  end

endmodule

/* sv/sbtd_out_stage.sv */
// sbtd_out_stage: result register driving the result channel.
// Depends on sbtd_pkg and sbtd_res_if.
module sbtd_out_stage
  import sbtd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t       res_i,
  output logic       free_o,
  sbtd_res_if.source res
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o = !valid_q || res.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res.valid       = valid_q;
  assign res.token_kind  = res_q.token_kind;
  assign res.opcode      = res_q.opcode;
  assign res.count       = res_q.count;
  assign res.reg_type    = res_q.reg_type;
  assign res.reg_num     = res_q.reg_num;
  assign res.select_bits = res_q.select_bits;
  assign res.modifier    = res_q.modifier;
  assign res.dst_shift   = signed'(res_q.dst_shift);
  assign res.flag_bits   = res_q.flag_bits;
  assign res.raw_value   = res_q.raw_value;
  assign res.instr_end   = res_q.instr_end;

endmodule

/* sv/sbtd_checker.sv */
// sbtd_checker: port-level assertions on the decoder result channel, bound
// to the top level. Depends on sbtd_pkg.
module sbtd_checker
  import sbtd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid,
  input logic        ready,
  input logic [3:0]  token_kind,
  input logic [31:0] raw_value,
  input logic        instr_end
);

  // a stalled result beat stays offered
  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && !ready |=> valid) else $error("result beat dropped while stalled");

  a_hold_raw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && !ready |=> $stable(raw_value)) else $error("stalled result changed");

  // an end token always closes its instruction
  a_end_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && token_kind == KindEnd |-> instr_end)
    else $error("end token not marked as last");

  // a declaration token is always followed by its destination
  a_dcl_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && token_kind == KindDcl |-> !instr_end)
    else $error("dcl token marked as last");

endmodule

bind shader_bytecode_token_decoder_core sbtd_checker u_sbtd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid      (res_out.valid),
  .ready      (res_out.ready),
  .token_kind (res_out.token_kind),
  .raw_value  (res_out.raw_value),
  .instr_end  (res_out.instr_end)
);

/* dv/shader_bytecode_token_decoder_core_tb.sv */
// testbench for shader_bytecode_token_decoder_core: feeds token beats, predicts every
// decoded result beat and checks it field by field, across several shader versions.
// depends on sbtd_pkg, sbtd_if and the decoder rtl.
module shader_bytecode_token_decoder_core_tb;
  import sbtd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned ResetCycles  = 11;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems   = 240;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned ReportLimit  = 10;

  localparam logic [CfgAddrW-1:0] VersionAddr = CfgAddrW'(4 * CfgRegVersion);
  localparam logic [15:0]         OpMov       = 16'd1;

  // decode predictor and store of expected result beats
  class decode_scoreboard;
    typedef enum logic [2:0] {
      PhHeader, PhDcl, PhDst, PhRelDst, PhOperand, PhRelSrc, PhDefWord, PhComment
    } phase_e;

    phase_e      phase;
    logic [1:0]  version;
    logic [14:0] slots_left;
    logic [3:0]  slot_idx;
    logic [15:0] cur_op;
    logic        predicated;
    logic [3:0]  src_idx;
    logic [2:0]  words_left;
    res_t        expected_q[$];
    int unsigned mismatches;
    int unsigned kind_count[10];

    function new();
      phase      = PhHeader;
      version    = VersionReset;
      slots_left = '0;
      slot_idx   = '0;
      cur_op     = '0;
      predicated = 1'b0;
      src_idx    = '0;
      words_left = '0;
      mismatches = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
    endfunction

    function bit at_header();
      return phase == PhHeader;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void fail_note(string msg);
      mismatches++;
      if (mismatches <= ReportLimit) $display("%s", msg);
    endfunction

    function bit flow_op(logic [15:0] op);
      case (op)
        OpIf, OpIfc, OpRep, OpLoop, OpBreakc, OpBreakp: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit def_op(logic [15:0] op);
      case (op)
        OpDef, OpDefi, OpDefb: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function logic [4:0] type_field(logic [31:0] t);
      return {t[12:11], t[30:28]};
    endfunction

    function logic [3:0] flag_field(logic [31:0] t);
      logic [3:0] f;
      f    = '0;
      f[0] = t[13];
      f[2] = t[22];
      f[3] = t[21];
      return f;
    endfunction

    function void step_slot();
      if (slot_idx != 4'hf) slot_idx++;
      if (slots_left != 0) slots_left--;
    endfunction

    function phase_e body_next();
      if (slots_left != 0) return PhOperand;
      return PhHeader;
    endfunction

    // dcl and def destinations leave the normal slot count alone
    function phase_e close_special();
      if (def_op(cur_op) && words_left != 0) begin
        slot_idx = '0;
        return PhDefWord;
      end
      return PhHeader;
    endfunction

    function void note_token(logic [31:0] t);
      res_t        e;
      phase_e      nxt;
      logic [14:0] len;
      logic        rel_reg;
      e           = '0;
      e.raw_value = t;
      nxt         = PhHeader;
      case (phase)
        PhHeader: begin
          cur_op     = t[15:0];
          predicated = t[28];
          src_idx    = '0;
          slot_idx   = '0;
          words_left = '0;
          if (cur_op == OpComment) len = t[30:16];
          else if (cur_op == OpEnd || cur_op == OpPhase) len = '0;
          else len = 15'(t[27:24]);
          slots_left    = len;
          e.token_kind  = KindInstr;
          e.count       = len;
          e.select_bits = t[23:16];
          e.flag_bits   = {2'b00, t[30], t[28]};
          if (cur_op == OpEnd) begin
            e.token_kind = KindEnd;
          end else if (cur_op == OpComment) begin
            nxt = (len != 0) ? PhComment : PhHeader;
          end else if (cur_op == OpDcl) begin
            nxt = PhDcl;
          end else if (def_op(cur_op)) begin
            if (len > 15'(DefWords)) words_left = 3'(DefWords);
            else if (len > 15'd1) words_left = 3'(len - 15'd1);
            nxt = PhDst;
          end else if (flow_op(cur_op)) begin
            nxt = (len != 0) ? PhOperand : PhHeader;
          end else begin
            nxt = (len != 0) ? PhDst : PhHeader;
          end
        end
        PhDcl: begin
          e.token_kind = KindDcl;
          e.reg_type   = {1'b0, t[30:27]};
          e.reg_num    = 11'(t[19:16]);
          e.modifier   = t[3:0];
          nxt          = PhDst;
        end
        PhDst: begin
          rel_reg       = t[13] && version == 2'd3;
          e.token_kind  = KindDst;
          e.reg_type    = type_field(t);
          e.reg_num     = t[10:0];
          e.select_bits = {4'h0, t[19:16]};
          e.dst_shift   = t[27:24];
          e.flag_bits   = flag_field(t) | {2'b00, t[20], 1'b0};
          if (cur_op == OpDcl || def_op(cur_op)) begin
            if (rel_reg) nxt = PhRelDst;
            else nxt = close_special();
          end else begin
            step_slot();
            if (rel_reg) nxt = PhRelDst;
            else nxt = body_next();
          end
        end
        PhRelDst, PhRelSrc: begin
          e.token_kind  = KindRelative;
          e.reg_type    = type_field(t);
          e.reg_num     = t[10:0];
          e.select_bits = t[23:16];
          if (phase == PhRelDst && (cur_op == OpDcl || def_op(cur_op))) begin
            nxt = close_special();
          end else begin
            step_slot();
            nxt = body_next();
          end
        end
        PhOperand: begin
          if (!flow_op(cur_op) && slot_idx == 4'd1 && predicated) begin
            e.token_kind  = KindPred;
            e.reg_type    = type_field(t);
            e.reg_num     = t[10:0];
            e.select_bits = t[23:16];
            e.modifier    = t[27:24];
            e.flag_bits   = flag_field(t);
            step_slot();
            nxt = body_next();
          end else if (src_idx >= MaxSources) begin
            // overrun: consumed and reported, never pulls a relative token
            e.token_kind = KindError;
            e.count      = 15'(src_idx);
            if (src_idx != 4'hf) src_idx++;
            step_slot();
            nxt = body_next();
          end else begin
            rel_reg       = t[13] && version >= 2'd2;
            e.token_kind  = KindSrc;
            e.count       = 15'(src_idx);
            e.reg_type    = type_field(t);
            e.reg_num     = t[10:0];
            e.select_bits = t[23:16];
            e.modifier    = t[27:24];
            e.flag_bits   = flag_field(t);
            if (src_idx != 4'hf) src_idx++;
            step_slot();
            if (rel_reg) nxt = PhRelSrc;
            else nxt = body_next();
          end
        end
        PhDefWord: begin
          e.token_kind = KindDefWord;
          e.count      = 15'(slot_idx);
          if (slot_idx != 4'hf) slot_idx++;
          if (words_left != 0) words_left--;
          nxt = (words_left != 0) ? PhDefWord : PhHeader;
        end
        default: begin
          e.token_kind = KindComment;
          if (slots_left != 0) slots_left--;
          nxt = (slots_left != 0) ? PhComment : PhHeader;
        end
      endcase
      phase       = nxt;
      e.opcode    = cur_op;
      e.instr_end = (nxt == PhHeader);
      expected_q.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        fail_note($sformatf("result beat with nothing expected: kind %0d raw %h",
                            got.token_kind, got.raw_value));
      end else begin
        e = expected_q.pop_front();
        if (e.token_kind < 10) kind_count[e.token_kind]++;
        if (got.token_kind !== e.token_kind || got.opcode !== e.opcode ||
            got.count !== e.count || got.reg_type !== e.reg_type ||
            got.reg_num !== e.reg_num || got.select_bits !== e.select_bits ||
            got.modifier !== e.modifier || got.dst_shift !== e.dst_shift ||
            got.flag_bits !== e.flag_bits || got.raw_value !== e.raw_value ||
            got.instr_end !== e.instr_end) begin
          fail_note($sformatf({"mismatch on token %h\n",
              "  expected kind %0d op %h count %0d type %h num %h sel %h mod %h ",
              "shift %h flags %h end %b\n",
              "  actual   kind %0d op %h count %0d type %h num %h sel %h mod %h ",
              "shift %h flags %h end %b raw %h"},
              e.raw_value,
              e.token_kind, e.opcode, e.count, e.reg_type, e.reg_num, e.select_bits,
              e.modifier, e.dst_shift, e.flag_bits, e.instr_end,
              got.token_kind, got.opcode, got.count, got.reg_type, got.reg_num,
              got.select_bits, got.modifier, got.dst_shift, got.flag_bits,
              got.instr_end, got.raw_value));
        end
      end
    endfunction
  endclass

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  bit                  steady;
  int unsigned         tokens_sent;
  int unsigned         cycle_count;
  decode_scoreboard    sb;

  sbtd_tok_if tok_if ();
  sbtd_res_if res_if ();

  shader_bytecode_token_decoder_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tok_in  (tok_if),
    .res_out (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= steady || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.token_kind, res_if.opcode, res_if.count, res_if.reg_type,
             res_if.reg_num, res_if.select_bits, res_if.modifier, res_if.dst_shift,
             res_if.flag_bits, res_if.raw_value, res_if.instr_end};
      sb.check_result(got);
    end
  end

  task automatic send_token(input logic [31:0] w);
    tok_if.valid      <= 1'b1;
    tok_if.token_word <= w;
    @(posedge clk_i);
    while (!tok_if.ready) @(posedge clk_i);
    sb.note_token(w);
    tokens_sent++;
    if (!steady && $urandom_range(99) < 8) begin
      tok_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic await_results();
    tok_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_version(input logic [1:0] v);
    logic [31:0] rd;
    await_results();
    repeat (SettleCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VersionAddr;
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[1:0] !== v)
      sb.fail_note($sformatf("version readback %h, wrote %h", rd[1:0], v));
    sb.version = v;
  endtask

  function automatic logic [31:0] make_header();
    logic [31:0] w;
    int unsigned r;
    w = $urandom;
    r = $urandom_range(99);
    if (r < 32) begin
      // arithmetic opcodes, now and then any opcode at all
      if ($urandom_range(9) == 0) w[15:0] = 16'($urandom);
      else w[15:0] = 16'($urandom_range(OpMov, OpLoop - 1));
      if ($urandom_range(4) == 0) w[27:24] = 4'($urandom_range(9, 15));
      else w[27:24] = 4'($urandom_range(5));
    end else if (r < 44) begin
      w[15:0] = OpDcl;
    end else if (r < 60) begin
      case ($urandom_range(2))
        0: w[15:0] = OpDef;
        1: w[15:0] = OpDefi;
        default: w[15:0] = OpDefb;
      endcase
      w[27:24] = 4'($urandom_range(7));
    end else if (r < 78) begin
      case ($urandom_range(5))
        0: w[15:0] = OpIf;
        1: w[15:0] = OpIfc;
        2: w[15:0] = OpRep;
        3: w[15:0] = OpLoop;
        4: w[15:0] = OpBreakc;
        default: w[15:0] = OpBreakp;
      endcase
      if ($urandom_range(4) == 0) w[27:24] = 4'($urandom_range(8, 15));
      else w[27:24] = 4'($urandom_range(4));
    end else if (r < 88) begin
      w[15:0]  = OpComment;
      w[30:16] = 15'($urandom_range(6));
    end else if (r < 95) begin
      w[15:0] = OpEnd;
    end else begin
      w[15:0] = OpPhase;
    end
    return w;
  endfunction

  function automatic logic [31:0] make_body();
    logic [31:0] w;
    w     = $urandom;
    w[13] = ($urandom_range(99) < 35);
    return w;
  endfunction

  task automatic run_opening();
    send_token(32'h0000_0000);
    send_token(32'hffff_ffff);
    // predicated, coissued; the relative destination beat takes the predicate slot
    send_token({8'h54, 8'h00, OpMov});
    send_token(32'h8f7f_3801);
    send_token(32'hb0e4_0000);
    send_token(32'h0be4_0802);
    send_token(32'h8dff_07ff);
    // dcl ignores its length field
    send_token({8'h0f, 8'h00, OpDcl});
    send_token(32'hffff_ffff);
    send_token(32'h800f_2000);
    send_token(32'hb000_0000);
    // def with length beyond the word cap
    send_token({8'h07, 8'h00, OpDef});
    send_token(32'ha00f_0001);
    send_token(32'h3f80_0000);
    send_token(32'h0000_0000);
    send_token(32'hffff_ffff);
    send_token(32'h1234_5678);
    send_token({8'h01, 8'h00, OpDefb});
    send_token(32'h800f_0000);
    // relative source read past the body length
    send_token({8'h01, 8'h00, OpIf});
    send_token(32'ha0e4_2000);
    send_token(32'hb000_0000);
    send_token({1'b0, 15'd2, OpComment});
    send_token(32'hdead_beef);
    send_token(32'h0000_ffff);
    send_token({16'h0000, OpComment});
  endtask

  initial begin : stimulus
    logic [1:0]  settings [5];
    logic [31:0] w;
    sb          = new();
    steady      = 1'b0;
    tokens_sent = 0;
    settings    = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd2};
    tok_if.valid      <= 1'b0;
    tok_if.token_word <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    run_opening();
    for (int p = 0; p < 5; p++) begin
      set_version(settings[p]);
      // one setting runs with neither side idling
      steady = (p == 3);
      for (int i = 0; i < PhaseItems; i++) begin
        if (i == PhaseItems / 2) await_results();
        if ($urandom_range(99) < 6) w = $urandom;
        else if (sb.at_header()) w = make_header();
        else w = make_body();
        send_token(w);
      end
    end
    steady = 1'b0;
    await_results();
    repeat (SettleCycles * 2) @(posedge clk_i);

    $display("%0d token beats over shader versions 3, 2, 0, 1, 3 and 2, with back-pressure",
             tokens_sent);
    $display("headers %0d, sources %0d, predicates %0d, relative %0d, overruns %0d, %s %0d",
             sb.kind_count[KindInstr], sb.kind_count[KindSrc], sb.kind_count[KindPred],
             sb.kind_count[KindRelative], sb.kind_count[KindError], "def words",
             sb.kind_count[KindDefWord]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
